[rtl/rfbc8_pkg.sv]
// Shared constants, types and the CRC-8 step for the response frame builder.
package rfbc8_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned LEN_W     = 3;
  localparam int unsigned IDX_W     = 4;
  localparam int unsigned FLEN_W    = 4;
  localparam int unsigned PAY_COUNT = 4;

  localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'hAA;
  localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'h55;
  localparam logic [BYTE_W-1:0] CRC_POLY    = 8'h07;
  localparam logic [BYTE_W-1:0] CRC_INIT    = 8'h00;
  localparam logic [LEN_W-1:0]  MAX_PAYLOAD = 3'd4;

  // Byte positions inside a frame
  localparam logic [IDX_W-1:0] POS_SYNC0   = 4'd0;
  localparam logic [IDX_W-1:0] POS_SYNC1   = 4'd1;
  localparam logic [IDX_W-1:0] POS_CMD     = 4'd2;
  localparam logic [IDX_W-1:0] POS_LEN     = 4'd3;
  localparam logic [IDX_W-1:0] POS_PAY0    = 4'd4;
  localparam logic [IDX_W-1:0] POS_PAY_END = 4'd7;
  localparam logic [IDX_W-1:0] POS_LAST    = 4'd8;

  // Header bytes plus the CRC byte
  localparam logic [FLEN_W-1:0] FRAME_OVERHEAD = 4'd5;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;
    logic emit;
  } rfbc8_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic last_byte;
  } rfbc8_status_t;

  // Fold one byte into the CRC, MSB first, no reflection
  function automatic logic [BYTE_W-1:0] crc8_update(input logic [BYTE_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] data);
    logic [BYTE_W-1:0] c;
    c = crc ^ data;
    for (int b = 0; b < BYTE_W; b++) begin
      if (c[BYTE_W-1]) begin
        c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[BYTE_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

[rtl/response_frame_builder_crc8.sv]
// Top level of the response frame builder with CRC-8 (poly 0x07).
//
// Request side: drive cmd, payload_len and pay0..pay3 with start high; the
// request is taken at a rising edge where start is high and busy is low.
// A payload_len above four is treated as four.
// Result side: the frame leaves as one beat per byte on out_byte, each
// marked by strobe for exactly one cycle: 0xAA, 0x55, cmd, length, the
// payload bytes, then the CRC-8 over all earlier bytes. is_last marks the
// CRC byte and every beat carries frame_length (payload length plus five).
// The accepting edge moves the controller to SEND, the first beat is then
// registered, and the beats of a frame follow on consecutive cycles.
// Throughput: frames may go back to back, set by the
// single byte-wide CRC unit that folds in one byte per cycle; busy drops
// while the CRC byte is prepared, so a new request may be taken then.
// The receiver cannot stall; every beat must be taken when it is shown.
// Reset (rst, synchronous, active high) returns the controller to idle and
// clears strobe and is_last; a frame in flight is dropped.
module response_frame_builder_crc8 (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [rfbc8_pkg::BYTE_W-1:0] cmd,
  input  logic [rfbc8_pkg::LEN_W-1:0]  payload_len,
  input  logic [rfbc8_pkg::BYTE_W-1:0] pay0,
  input  logic [rfbc8_pkg::BYTE_W-1:0] pay1,
  input  logic [rfbc8_pkg::BYTE_W-1:0] pay2,
  input  logic [rfbc8_pkg::BYTE_W-1:0] pay3,
  output logic                         strobe,
  output logic [rfbc8_pkg::BYTE_W-1:0] out_byte,
  output logic                         is_last,
  output logic [rfbc8_pkg::FLEN_W-1:0] frame_length
);
  import rfbc8_pkg::*;

  rfbc8_cmd_t    ctrl_cmd;
  rfbc8_status_t dp_status;

  rfbc8_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd_o  (ctrl_cmd),
    .status (dp_status)
  );

  rfbc8_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd_i        (ctrl_cmd),
    .status       (dp_status),
    .cmd          (cmd),
    .payload_len  (payload_len),
    .pay0         (pay0),
    .pay1         (pay1),
    .pay2         (pay2),
    .pay3         (pay3),
    .strobe       (strobe),
    .out_byte     (out_byte),
    .is_last      (is_last),
    .frame_length (frame_length)
  );

endmodule

[rtl/rfbc8_ctrl.sv]
// Controller state machine: sequences request capture and byte emission.
module rfbc8_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  output rfbc8_pkg::rfbc8_cmd_t    cmd_o,
  input  rfbc8_pkg::rfbc8_status_t status
);
  import rfbc8_pkg::*;

  typedef enum logic {
    IDLE,
    SEND
  } state_t;

  state_t state;
  state_t state_next;

  // Free the request side while the CRC byte goes out
  assign busy       = (state == SEND) && !status.last_byte;
  assign cmd_o.load = start && !busy;
  assign cmd_o.emit = (state == SEND);

  // Advance the frame sequence
  always_comb begin
    state_next = state;
    case (state)
      IDLE: begin
        if (cmd_o.load) state_next = SEND;
      end
      SEND: begin
        if (status.last_byte && !cmd_o.load) state_next = IDLE;
      end
      default: state_next = IDLE;
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[rtl/rfbc8_dp.sv]
// Datapath: request registers, byte selector, running CRC and output beat.
module rfbc8_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  rfbc8_pkg::rfbc8_cmd_t               cmd_i,
  output rfbc8_pkg::rfbc8_status_t            status,
  input  logic [rfbc8_pkg::BYTE_W-1:0]        cmd,
  input  logic [rfbc8_pkg::LEN_W-1:0]         payload_len,
  input  logic [rfbc8_pkg::BYTE_W-1:0]        pay0,
  input  logic [rfbc8_pkg::BYTE_W-1:0]        pay1,
  input  logic [rfbc8_pkg::BYTE_W-1:0]        pay2,
  input  logic [rfbc8_pkg::BYTE_W-1:0]        pay3,
  output logic                                strobe,
  output logic [rfbc8_pkg::BYTE_W-1:0]        out_byte,
  output logic                                is_last,
  output logic [rfbc8_pkg::FLEN_W-1:0]        frame_length
);
  import rfbc8_pkg::*;

  logic [BYTE_W-1:0] cmd_r;
  logic [BYTE_W-1:0] pay_r [PAY_COUNT];
  logic [LEN_W-1:0]  len_r;
  logic [IDX_W-1:0]  idx;
  logic [BYTE_W-1:0] crc;
  logic [LEN_W-1:0]  len_sat;
  logic [BYTE_W-1:0] body_byte;
  logic              last_byte;

  // Clamp oversized lengths to the payload capacity
  assign len_sat = (payload_len > MAX_PAYLOAD) ? MAX_PAYLOAD : payload_len;

  // The CRC byte sits right after the last payload byte
  assign last_byte        = (idx == (IDX_W'(len_r) + POS_PAY0));
  assign status.last_byte = last_byte;

  // Select the current body byte
  always_comb begin
    case (idx) inside
      POS_SYNC0:              body_byte = SYNC_FIRST;
      POS_SYNC1:              body_byte = SYNC_SECOND;
      POS_CMD:                body_byte = cmd_r;
      POS_LEN:                body_byte = BYTE_W'(len_r);
      [POS_PAY0:POS_PAY_END]: body_byte = pay_r[idx[1:0]];
      default:                body_byte = crc;
    endcase
  end

  // Capture the request, or advance index and CRC
  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      cmd_r    <= cmd;
      pay_r[0] <= pay0;
      pay_r[1] <= pay1;
      pay_r[2] <= pay2;
      pay_r[3] <= pay3;
      len_r    <= len_sat;
      idx      <= POS_SYNC0;
      crc      <= CRC_INIT;
    end else if (cmd_i.emit && !last_byte) begin
      idx <= idx + 1'b1;
      crc <= crc8_update(crc, body_byte);
    end
  end

  // Drive the output beat
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe  <= 1'b0;
      is_last <= 1'b0;
    end else begin
      strobe  <= cmd_i.emit;
      is_last <= cmd_i.emit && last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.emit) begin
      out_byte     <= last_byte ? crc : body_byte;
      frame_length <= FLEN_W'(len_r) + FRAME_OVERHEAD;
    end
  end

  // Checks
  a_last_has_strobe: assert property (@(posedge clk) disable iff (rst)
    is_last |-> strobe)
    else $error("is_last raised without a beat");

  a_frame_contiguous: assert property (@(posedge clk) disable iff (rst)
    (strobe && !is_last) |=> strobe)
    else $error("frame beats not contiguous");

  a_length_steady: assert property (@(posedge clk) disable iff (rst)
    (strobe && !is_last) |=> (frame_length == $past(frame_length)))
    else $error("frame_length changed inside a frame");

  a_emit_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd_i.emit |-> (idx <= POS_LAST))
    else $error("byte index beyond frame end");

endmodule

[test/tb_top.sv]
// Self-checking testbench for the CRC-8 response frame builder.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rfbc8_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 100000;
  localparam int          RANDOM_COUNT = 430;
  localparam int          CALM_FROM    = 370;  // no sender gaps from this item on
  localparam int          DRAIN_AT     = 200;

  // One expected frame byte
  typedef struct {
    logic [BYTE_W-1:0] data;
    logic              last;
    logic [FLEN_W-1:0] flen;
  } frame_beat_t;

  // Builds expected frames from accepted requests and checks the byte stream
  class frame_tracker;
    frame_beat_t bytes_due[$];
    int          mismatches = 0;
    int          frames_seen = 0;
    int          beats_seen = 0;
    int          saturated_seen = 0;

    // Shift the byte through the CRC one bit at a time, MSB first
    function automatic logic [BYTE_W-1:0] crc_fold(logic [BYTE_W-1:0] crc,
                                                   logic [BYTE_W-1:0] b);
      logic fb;
      for (int i = BYTE_W - 1; i >= 0; i--) begin
        fb  = crc[BYTE_W-1] ^ b[i];
        crc = {crc[BYTE_W-2:0], 1'b0};
        if (fb) crc = crc ^ CRC_POLY;
      end
      return crc;
    endfunction

    function automatic void note_request(logic [BYTE_W-1:0] c, logic [LEN_W-1:0] l,
                                         logic [BYTE_W-1:0] p0, logic [BYTE_W-1:0] p1,
                                         logic [BYTE_W-1:0] p2, logic [BYTE_W-1:0] p3);
      logic [BYTE_W-1:0] frame [9];
      logic [BYTE_W-1:0] pays [4];
      logic [LEN_W-1:0]  eff;
      logic [BYTE_W-1:0] crc;
      int                body;
      frame_beat_t       bt;
      pays[0] = p0;
      pays[1] = p1;
      pays[2] = p2;
      pays[3] = p3;
      // Clamp an oversize length to the full payload
      eff = (l > MAX_PAYLOAD) ? MAX_PAYLOAD : l;
      if (l > MAX_PAYLOAD) saturated_seen++;
      frame[0] = SYNC_FIRST;
      frame[1] = SYNC_SECOND;
      frame[2] = c;
      frame[3] = BYTE_W'(eff);
      for (int i = 0; i < int'(eff); i++) frame[4 + i] = pays[i];
      body = int'(eff) + 4;
      crc  = CRC_INIT;
      for (int i = 0; i < body; i++) crc = crc_fold(crc, frame[i]);
      frame[body] = crc;
      for (int i = 0; i <= body; i++) begin
        bt.data = frame[i];
        bt.last = (i == body);
        bt.flen = FLEN_W'(body + 1);
        bytes_due.push_back(bt);
      end
      frames_seen++;
    endfunction

    function automatic void check_beat(logic [BYTE_W-1:0] data, logic last,
                                       logic [FLEN_W-1:0] flen);
      frame_beat_t want;
      beats_seen++;
      if (bytes_due.size() == 0) begin
        $error("unexpected beat: out_byte %02h is_last %0b frame_length %0d",
               data, last, flen);
        mismatches++;
        return;
      end
      want = bytes_due.pop_front();
      if (data !== want.data) begin
        $error("out_byte mismatch: expected %02h, got %02h", want.data, data);
        mismatches++;
      end
      if (last !== want.last) begin
        $error("is_last mismatch: expected %0b, got %0b", want.last, last);
        mismatches++;
      end
      if (flen !== want.flen) begin
        $error("frame_length mismatch: expected %0d, got %0d", want.flen, flen);
        mismatches++;
      end
    endfunction

    function automatic int pending();
      return bytes_due.size();
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst;
  logic                start;
  logic                busy;
  logic [BYTE_W-1:0]   cmd;
  logic [LEN_W-1:0]    payload_len;
  logic [BYTE_W-1:0]   pay0;
  logic [BYTE_W-1:0]   pay1;
  logic [BYTE_W-1:0]   pay2;
  logic [BYTE_W-1:0]   pay3;
  logic                strobe;
  logic [BYTE_W-1:0]   out_byte;
  logic                is_last;
  logic [FLEN_W-1:0]   frame_length;
  int unsigned         cycles = 0;
  frame_tracker        frames;

  response_frame_builder_crc8 u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .payload_len  (payload_len),
    .pay0         (pay0),
    .pay1         (pay1),
    .pay2         (pay2),
    .pay3         (pay3),
    .strobe       (strobe),
    .out_byte     (out_byte),
    .is_last      (is_last),
    .frame_length (frame_length)
  );

  always #2 clk = ~clk;

  // Note accepted requests and check every strobed byte
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) frames.note_request(cmd, payload_len, pay0, pay1, pay2, pay3);
      if (strobe) frames.check_beat(out_byte, is_last, frame_length);
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Present one request and hold it until the block takes it
  task automatic send_request(input logic [BYTE_W-1:0] c, input logic [LEN_W-1:0] l,
                              input logic [BYTE_W-1:0] p0, input logic [BYTE_W-1:0] p1,
                              input logic [BYTE_W-1:0] p2, input logic [BYTE_W-1:0] p3);
    cmd         <= c;
    payload_len <= l;
    pay0        <= p0;
    pay1        <= p1;
    pay2        <= p2;
    pay3        <= p3;
    start       <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  task automatic pause_sender(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Hold off until every outstanding byte has been seen
  task automatic drain_frames();
    start <= 1'b0;
    while (frames.pending() != 0) @(posedge clk);
  endtask

  task automatic send_random();
    logic [LEN_W-1:0] l;
    // Mostly legal lengths, some oversize ones
    if ($urandom_range(0, 99) < 85) l = LEN_W'($urandom_range(0, 4));
    else l = LEN_W'($urandom_range(5, 7));
    send_request(BYTE_W'($urandom_range(0, 255)), l,
                 BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)),
                 BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)));
  endtask

  initial begin
    frames = new();
    rst         <= 1'b1;
    start       <= 1'b0;
    cmd         <= '0;
    payload_len <= '0;
    pay0        <= '0;
    pay1        <= '0;
    pay2        <= '0;
    pay3        <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: field extremes, every length, oversize lengths, ignored bytes
    send_request(8'h00, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00);
    send_request(8'hFF, 3'd4, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_request(8'h5A, 3'd1, 8'h80, 8'hFF, 8'hFF, 8'hFF);
    send_request(8'hA5, 3'd2, 8'h01, 8'hFE, 8'h77, 8'h99);
    send_request(8'h3C, 3'd3, 8'hAA, 8'h55, 8'hC3, 8'hFF);
    send_request(8'hAA, 3'd0, 8'hDE, 8'hAD, 8'hBE, 8'hEF);
    send_request(8'h55, 3'd4, 8'h12, 8'h34, 8'h56, 8'h78);
    pause_sender(3);
    send_request(8'h81, 3'd5, 8'h01, 8'h02, 8'h04, 8'h08);
    send_request(8'h42, 3'd6, 8'h10, 8'h20, 8'h40, 8'h80);
    send_request(8'h7E, 3'd7, 8'hFF, 8'h00, 8'hFF, 8'h00);
    pause_sender(1);
    send_request(8'h01, 3'd4, 8'h00, 8'h00, 8'h00, 8'h00);
    send_request(8'hFE, 3'd1, 8'hFF, 8'h00, 8'h00, 8'h00);
    send_request(8'h00, 3'd7, 8'h00, 8'h00, 8'h00, 8'h00);
    send_request(8'hFF, 3'd0, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    drain_frames();

    // Random requests with bursty sender gaps, calm towards the end
    for (int n = 0; n < RANDOM_COUNT; n++) begin
      send_random();
      if (n == DRAIN_AT) drain_frames();
      else if (n < CALM_FROM && $urandom_range(0, 2) == 0) pause_sender($urandom_range(1, 9));
    end
    drain_frames();
    repeat (12) @(posedge clk);

    if (frames.pending() != 0) begin
      $error("%0d frame bytes never arrived", frames.pending());
      frames.mismatches++;
    end
    $display("Covered %0d frames (%0d with an oversize length), %0d bytes checked.",
             frames.frames_seen, frames.saturated_seen, frames.beats_seen);
    $display("Lengths 0 to 7, field extremes and bursty request gaps were exercised.");
    if (frames.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
